>>> rtl/assert_macros.svh
// Assertion macros used by the RGB to HSV converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define RHV_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Checks that a condition never holds at a rising edge outside reset.
`define RHV_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);

`endif

>>> rtl/rgb2hsv_pkg.sv
// Types and constants of the RGB to HSV converter.
package rgb2hsv_pkg;

  localparam int CB       = 8;
  localparam int HUE_W    = 9;
  localparam int NSTEP    = HUE_W;
  localparam int RW       = (2 * CB > CB + HUE_W) ? 2 * CB : CB + HUE_W;
  localparam int NSW      = RW + 1;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  localparam int HUE_STEP  = 60;
  localparam int HUE_GREEN = 120;
  localparam int HUE_BLUE  = 240;
  localparam int HUE_TURN  = 360;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_degrees;
    logic [CB-1:0]    saturation;
    logic [CB-1:0]    brightness;
    logic             hue_undefined;
  } hsv_t;

  typedef struct packed {
    logic [CB-1:0]        mx;
    logic [CB-1:0]        dlt;
    logic signed [CB:0]   diff;
    sector_t              sector;
  } qent_t;

  typedef struct packed {
    logic             undef;
    logic [CB-1:0]    mx;
    logic [CB-1:0]    dlt;
    logic [RW-1:0]    hrem;
    logic [RW-1:0]    srem;
    logic [HUE_W-1:0] hq;
    logic [HUE_W-1:0] sq;
  } stage_t;

endpackage

>>> rtl/rgb2hsv_front.sv
// Front part: takes pixels, finds the largest and smallest component and the hue sector.
module rgb2hsv_front import rgb2hsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  pixel_t pixel,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  logic   q_full,
  output logic   q_push,
  output qent_t  q_data
);

  logic  fr_valid;
  qent_t ent;
  qent_t ent_next;
  logic  [CB-1:0] mn;

  assign pixel_stall = fr_valid && q_full;
  assign q_push      = fr_valid && !q_full;
  assign q_data      = ent;

  always_comb begin
    ent_next = '0;
    if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
      ent_next.mx     = pixel.red;
      ent_next.sector = SECT_RED;
      ent_next.diff   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
    end else if (pixel.green >= pixel.blue) begin
      ent_next.mx     = pixel.green;
      ent_next.sector = SECT_GREEN;
      ent_next.diff   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
    end else begin
      ent_next.mx     = pixel.blue;
      ent_next.sector = SECT_BLUE;
      ent_next.diff   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
    end
    if (pixel.red <= pixel.green && pixel.red <= pixel.blue) begin
      mn = pixel.red;
    end else if (pixel.green <= pixel.blue) begin
      mn = pixel.green;
    end else begin
      mn = pixel.blue;
    end
    ent_next.dlt = ent_next.mx - mn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (!pixel_stall) begin
      fr_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pixel_stall && pixel_valid) begin
      ent <= ent_next;
    end
  end

endmodule

>>> rtl/rgb2hsv_queue.sv
// Short queue between the front and back parts.
module rgb2hsv_queue import rgb2hsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t rdata
);

  qent_t          ent [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;

  assign full  = (cnt == (QAW + 1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign rdata = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= wdata;
    end
  end

endmodule

>>> rtl/rgb2hsv_back.sv
// Back part: hue numerator set-up and pipelined restoring division for hue and saturation.
module rgb2hsv_back import rgb2hsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_empty,
  input  qent_t q_data,
  output logic  q_pop,
  output hsv_t  hsv,
  output logic  hsv_valid,
  input  logic  hsv_stall
);

  stage_t              st [NSTEP+1];
  logic [NSTEP:0]      vld;
  logic                adv;
  stage_t              prep;
  logic signed [NSW-1:0] dext;
  logic signed [NSW-1:0] off;
  logic signed [NSW-1:0] num;

  assign adv       = !vld[NSTEP] || !hsv_stall;
  assign q_pop     = adv && !q_empty;
  assign hsv_valid = vld[NSTEP];

  always_comb begin
    dext = signed'(NSW'(q_data.dlt));
    unique case (q_data.sector)
      SECT_RED:   off = '0;
      SECT_GREEN: off = dext * signed'(NSW'(HUE_GREEN));
      SECT_BLUE:  off = dext * signed'(NSW'(HUE_BLUE));
      default:    off = '0;
    endcase
    num = NSW'(q_data.diff) * signed'(NSW'(HUE_STEP)) + off;
    if (num < 0) begin
      num = num + dext * signed'(NSW'(HUE_TURN));
    end
    prep       = '0;
    prep.undef = (q_data.dlt == '0);
    prep.mx    = q_data.mx;
    prep.dlt   = q_data.dlt;
    prep.hrem  = RW'(num);
    prep.srem  = RW'({q_data.dlt, CB'(0)}) - RW'(q_data.dlt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTEP-1:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= prep;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [RW-1:0] hd;
    logic [RW-1:0] sd;
    stage_t        nx;

    always_comb begin
      nx = st[k-1];
      hd = RW'(st[k-1].dlt) << (NSTEP - k);
      sd = RW'(st[k-1].mx) << (NSTEP - k);
      if (st[k-1].hrem >= hd) begin
        nx.hrem          = st[k-1].hrem - hd;
        nx.hq[NSTEP - k] = 1'b1;
      end
      if (st[k-1].srem >= sd) begin
        nx.srem          = st[k-1].srem - sd;
        nx.sq[NSTEP - k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k] <= nx;
      end
    end
  end

  always_comb begin
    hsv.hue_undefined = st[NSTEP].undef;
    hsv.brightness    = st[NSTEP].mx;
    hsv.hue_degrees   = st[NSTEP].undef ? '0 : st[NSTEP].hq;
    hsv.saturation    = st[NSTEP].undef ? '0 : st[NSTEP].sq[CB-1:0];
  end

endmodule

>>> rtl/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV converter.
//
// Pixels enter on the pixel channel (pixel, pixel_valid, pixel_stall) and
// results leave on the hsv channel (hsv, hsv_valid, hsv_stall). A beat is
// taken at a rising edge where valid is high and stall is low.
// Each pixel gives exactly one result, in order.
// An accepted pixel beat passes one front register, one queue slot, one
// set-up stage and nine restoring division steps that produce hue and
// saturation together. Throughput is one pixel per cycle while hsv_stall
// is low; the division pipeline sets that figure, since each of its stages
// retires one quotient bit of hue and of saturation. When hsv_stall is high
// and a result waits, the back pipeline holds, the four-entry queue fills
// and pixel_stall rises once the queue and the front register are full.
// Reset empties the queue and the pipeline; no clearing pass is needed.
module rgb_to_hsv_converter_core import rgb2hsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  pixel_t pixel,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  output hsv_t   hsv,
  output logic   hsv_valid,
  input  logic   hsv_stall
);

  `include "assert_macros.svh"

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  qent_t q_wdata;
  qent_t q_rdata;

  rgb2hsv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  rgb2hsv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  rgb2hsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .hsv       (hsv),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall)
  );

  `RHV_ASSERT(a_undef_zero, clk, rst, hsv_valid && hsv.hue_undefined |-> hsv.hue_degrees == '0 && hsv.saturation == '0, "undefined hue with nonzero hue or saturation")
  `RHV_ASSERT(a_hue_range, clk, rst, hsv_valid && !hsv.hue_undefined |-> hsv.hue_degrees < HUE_W'(HUE_TURN), "hue out of range")
  `RHV_ASSERT(a_sat_nonzero, clk, rst, hsv_valid && !hsv.hue_undefined |-> hsv.saturation != '0 && hsv.brightness != '0, "colored pixel with zero saturation or value")
  `RHV_NEVER(a_stall_queue, clk, rst, pixel_stall && !q_full, "input stalled while queue has room")

endmodule
